### design/stereo_peak_limiter_saturator_core_defines.svh
// Assertion macros shared by the limiter RTL.
// No dependencies; included by the modules that carry checks.
`ifndef STEREO_PEAK_LIMITER_SATURATOR_CORE_DEFINES_SVH
`define STEREO_PEAK_LIMITER_SATURATOR_CORE_DEFINES_SVH

// same-cycle implication
`define SPL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spl: assertion failed");

// next-cycle implication
`define SPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spl: assertion failed");

`endif

### design/spl_pkg.sv
// Package for the stereo limiter: widths, config and queue types, constants.
// No dependencies.
`timescale 1ns / 1ps
package spl_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int ENV_FRAC_BITS = 32;

  localparam int MAG_W   = SAMPLE_BITS;
  localparam int ENV_W   = SAMPLE_BITS + ENV_FRAC_BITS - 20;
  localparam int EXT_W   = (ENV_W > 32) ? ENV_W : 33;
  localparam int HI_W    = EXT_W - 32;
  localparam int ROOT_W  = (SAMPLE_BITS + 21) / 2;
  localparam int SQX_W   = 2 * ROOT_W;
  localparam int SQ_SHIFT = 40 - ENV_FRAC_BITS;
  localparam int GAIN_W  = (ROOT_W > 21) ? ROOT_W : 21;
  localparam int DEN_W   = GAIN_W;
  localparam int DIV_STEPS = 20;

  localparam logic [20:0] ONE_Q20 = 21'h100000;
  localparam logic [30:0] ONE_Q30 = 31'h40000000;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam int SINE_TERMS = 6;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_CEILING   = 3'd1,
    REG_SAT_AMT   = 3'd2,
    REG_SAT_NORM  = 3'd3,
    REG_ENV_COEFF = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [20:0] threshold_amp;
    logic [20:0] ceiling_amp;
    logic [19:0] saturation_amount;
    logic [20:0] saturation_norm;
    logic [31:0] envelope_coeff;
  } cfg_t;

  typedef struct packed {
    logic [MAG_W-1:0]  lmag;
    logic              lneg;
    logic [MAG_W-1:0]  rmag;
    logic              rneg;
    logic [GAIN_W-1:0] gain;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // divisors k*(k+1) of the sine series, k = 12, 10, 8, 6, 4, 2, with floor(2^32/d)
  function automatic logic [39:0] sine_div(input logic [2:0] idx);
    logic [39:0] v;
    case (idx)
      3'd0:    v = {8'd156, 32'(64'h1_0000_0000 / 156)};
      3'd1:    v = {8'd110, 32'(64'h1_0000_0000 / 110)};
      3'd2:    v = {8'd72,  32'(64'h1_0000_0000 / 72)};
      3'd3:    v = {8'd42,  32'(64'h1_0000_0000 / 42)};
      3'd4:    v = {8'd20,  32'(64'h1_0000_0000 / 20)};
      default: v = {8'd6,   32'(64'h1_0000_0000 / 6)};
    endcase
    return v;
  endfunction

endpackage

### design/stereo_peak_limiter_saturator_core.sv
// Stereo peak limiter with sine saturator: top level, config registers.
// Depends on spl_pkg, spl_front, spl_queue, spl_back (spl_divider).
//
// Usage:
//   Input channel: in_valid / in_stall with left_in, right_in (24-bit signed,
//   1.0 = 2^20). A transaction is taken when in_valid is high and in_stall low.
//   Output channel: out_valid / out_stall with left_out, right_out (22-bit
//   signed, within +-2^20); one result transaction per input transaction.
//   Config: cfg_write, cfg_index, cfg_data write one register per cycle;
//   write only while the block is idle.
//   Front end: envelope multiply, 22-step square root, push; in_stall is
//   high whenever it is busy. Back end, per channel: a gain division
//   (skipped when the sample clamps), and with the saturator on a sine
//   series of six multiply/reciprocal steps plus a second division. The
//   back end sets the rate.
//   Reset (rst, synchronous) restores register defaults and a zero envelope.
//   While out_stall is high the result is held and the two-entry queue fills,
//   after which the front end holds in_stall high.
`timescale 1ns / 1ps
module stereo_peak_limiter_saturator_core
  import spl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [MAG_W-1:0] left_in,
  input  logic signed [MAG_W-1:0] right_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [21:0]      left_out,
  output logic signed [21:0]      right_out
);

  cfg_t   cfg;
  qstat_t qstat;
  entry_t push_entry, head;
  logic   push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_amp     <= ONE_Q20;
      cfg.ceiling_amp       <= ONE_Q20;
      cfg.saturation_amount <= '0;
      cfg.saturation_norm   <= ONE_Q20;
      cfg.envelope_coeff    <= 32'd4863882;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg.threshold_amp     <= cfg_data[20:0];
        REG_CEILING:   cfg.ceiling_amp       <= cfg_data[20:0];
        REG_SAT_AMT:   cfg.saturation_amount <= cfg_data[19:0];
        REG_SAT_NORM:  cfg.saturation_norm   <= cfg_data[20:0];
        REG_ENV_COEFF: cfg.envelope_coeff    <= cfg_data;
        default: ;
      endcase
    end
  end

  spl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left_in    (left_in),
    .right_in   (right_in),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  spl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  spl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule

### design/spl_front.sv
// Front end: takes a stereo pair, updates the envelope, takes its square root
// and forms the gain. Depends on spl_pkg.
`timescale 1ns / 1ps
`include "stereo_peak_limiter_saturator_core_defines.svh"
module spl_front
  import spl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [MAG_W-1:0] left_in,
  input  logic signed [MAG_W-1:0] right_in,
  input  qstat_t                 qstat,
  output logic                   push,
  output entry_t                 push_entry
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_ENV  = 5'b00100,
    F_SQRT = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  localparam int CNT_W = $clog2(ROOT_W);

  fstate_t state;
  logic [MAG_W-1:0]  lmag, rmag;
  logic              lneg, rneg;
  logic [ENV_W-1:0]  env;
  logic              up;
  logic [63:0]       prod_lo;
  logic [HI_W+31:0]  prod_hi;
  logic [SQX_W-1:0]  sqx;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W+1:0] srem;
  logic [CNT_W-1:0]  cnt;

  logic [MAG_W-1:0]  lmag_in, rmag_in, det;
  logic [ENV_W-1:0]  target, diff;
  logic [EXT_W-1:0]  diff_ext;
  logic [HI_W+31:0]  step;
  logic [ROOT_W+3:0] rem_s, trial;
  logic [GAIN_W-1:0] level_g, thr_g, gain;

  assign lmag_in = left_in[MAG_W-1]  ? MAG_W'(-left_in)  : MAG_W'(left_in);
  assign rmag_in = right_in[MAG_W-1] ? MAG_W'(-right_in) : MAG_W'(right_in);
  assign det     = (lmag > rmag) ? lmag : rmag;
  assign target  = ENV_W'(det) << (ENV_FRAC_BITS - 20);
  assign diff    = (target >= env) ? target - env : env - target;
  assign diff_ext = EXT_W'(diff);
  assign step    = prod_hi + (HI_W+32)'(prod_lo[63:32]);

  assign rem_s = {srem, sqx[SQX_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};

  assign level_g = GAIN_W'(root);
  assign thr_g   = GAIN_W'(cfg.threshold_amp);
  always_comb begin
    gain = (level_g > thr_g) ? level_g : thr_g;
    if (gain == '0) gain = GAIN_W'(1);
  end

  assign in_stall = (state != F_IDLE);
  assign push     = (state == F_PUSH) && !qstat.full;
  assign push_entry = '{lmag: lmag, lneg: lneg, rmag: rmag, rneg: rneg, gain: gain};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      env   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            lmag  <= lmag_in;
            rmag  <= rmag_in;
            lneg  <= left_in[MAG_W-1];
            rneg  <= right_in[MAG_W-1];
            state <= F_MUL;
          end
        end
        F_MUL: begin
          up      <= (target >= env);
          prod_lo <= diff_ext[31:0] * cfg.envelope_coeff;
          prod_hi <= diff_ext[EXT_W-1:32] * cfg.envelope_coeff;
          state   <= F_ENV;
        end
        F_ENV: begin
          env   <= up ? env + ENV_W'(step) : env - ENV_W'(step);
          state <= F_SQRT;
          cnt   <= '0;
          root  <= '0;
          srem  <= '0;
          sqx   <= SQX_W'(up ? env + ENV_W'(step) : env - ENV_W'(step)) << SQ_SHIFT;
        end
        F_SQRT: begin
          if (rem_s >= trial) begin
            srem <= (ROOT_W+2)'(rem_s - trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            srem <= (ROOT_W+2)'(rem_s);
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          sqx <= sqx << 2;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(ROOT_W - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!qstat.full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `SPL_ASSERT_IMPLY(a_gain_nonzero, clk, rst, push, push_entry.gain != '0)

endmodule

### design/spl_queue.sv
// Two-entry queue between the gain front end and the shaping back end.
// Depends on spl_pkg.
`timescale 1ns / 1ps
`include "stereo_peak_limiter_saturator_core_defines.svh"
module spl_queue
  import spl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output qstat_t qstat
);

  entry_t     mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head        = mem[rd_ptr];
  assign qstat.empty = (count == 2'd0);
  assign qstat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `SPL_ASSERT_IMPLY(a_no_overflow, clk, rst, push, !qstat.full)
  `SPL_ASSERT_IMPLY(a_no_underflow, clk, rst, pop, !qstat.empty)

endmodule

### design/spl_divider.sv
// Restoring divider: (num_hi*2^20 + num_lo) / den, 20 quotient bits, num_hi < den.
// One bit per cycle. Depends on spl_pkg.
`timescale 1ns / 1ps
`include "stereo_peak_limiter_saturator_core_defines.svh"
module spl_divider
  import spl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEN_W-1:0] num_hi,
  input  logic [19:0]      num_lo,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [19:0]      quot
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy;
  logic [DEN_W-1:0] rem, dreg;
  logic [19:0]      lo;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   r2;

  assign r2 = {rem, lo[19]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        rem  <= num_hi;
        lo   <= num_lo;
        dreg <= den;
        cnt  <= '0;
      end else if (busy) begin
        if (r2 >= {1'b0, dreg}) begin
          rem  <= DEN_W'(r2 - {1'b0, dreg});
          quot <= {quot[18:0], 1'b1};
        end else begin
          rem  <= DEN_W'(r2);
          quot <= {quot[18:0], 1'b0};
        end
        lo  <= lo << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `SPL_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)

endmodule

### design/spl_back.sv
// Back end: per channel divide by gain, optional sine saturator, ceiling scale.
// Depends on spl_pkg and spl_divider.
`timescale 1ns / 1ps
`include "stereo_peak_limiter_saturator_core_defines.svh"
module spl_back
  import spl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  qstat_t             qstat,
  input  entry_t             head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [21:0] left_out,
  output logic signed [21:0] right_out
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'b0000000000000001,
    S_LOAD    = 16'b0000000000000010,
    S_DIV1    = 16'b0000000000000100,
    S_PHASE_M = 16'b0000000000001000,
    S_PHASE   = 16'b0000000000010000,
    S_T       = 16'b0000000000100000,
    S_T2      = 16'b0000000001000000,
    S_RMUL    = 16'b0000000010000000,
    S_RDIV    = 16'b0000000100000000,
    S_RCOR    = 16'b0000001000000000,
    S_SIN     = 16'b0000010000000000,
    S_SINF    = 16'b0000100000000000,
    S_DIV2    = 16'b0001000000000000,
    S_CEIL_M  = 16'b0010000000000000,
    S_CEIL    = 16'b0100000000000000,
    S_OUT     = 16'b1000000000000000
  } bstate_t;

  localparam int CMP_W = MAG_W + GAIN_W;

  bstate_t state;
  entry_t  ent;
  logic    ch;
  logic [20:0] q, y;
  logic [30:0] t, r;
  logic [31:0] t2, x;
  logic [2:0]  kidx;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;

  logic [MAG_W-1:0] mag;
  logic             neg;
  logic [20:0]      p;
  logic [19:0]      pf;
  logic [39:0]      kd;
  logic [31:0]      q0, rem, qq;
  logic [20:0]      norm;
  logic [21:0]      o;
  logic [20:0]      oc;
  logic signed [21:0] res;

  logic             div_start, div_done;
  logic [DEN_W-1:0] div_hi, div_den;
  logic [19:0]      div_lo, div_q;

  spl_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_hi (div_hi),
    .num_lo (div_lo),
    .den    (div_den),
    .done   (div_done),
    .quot   (div_q)
  );

  assign mag  = ch ? ent.rmag : ent.lmag;
  assign neg  = ch ? ent.rneg : ent.lneg;
  assign norm = (cfg.saturation_norm == '0) ? 21'd1 : cfg.saturation_norm;
  assign kd   = sine_div(kidx);
  assign q0   = prod[63:32];
  assign rem  = x - 32'(q0 * kd[39:32]);
  assign qq   = q0 + ((rem >= 32'(kd[39:32])) ? 32'd1 : 32'd0);
  assign o    = prod[41:20];
  assign oc   = (o > 22'(ONE_Q20)) ? ONE_Q20 : o[20:0];
  assign res  = neg ? -$signed({1'b0, oc}) : $signed({1'b0, oc});

  always_comb begin
    p = prod[40:20];
    if (p > ONE_Q20) p = ONE_Q20;
    if (p > (ONE_Q20 >> 1)) p = ONE_Q20 - p;
    pf = p[19:0];
  end

  always_comb begin
    div_start = 1'b0;
    div_hi    = DEN_W'(mag);
    div_lo    = '0;
    div_den   = ent.gain;
    if (state == S_LOAD) begin
      div_start = (CMP_W'(mag) < CMP_W'(ent.gain));
    end else if (state == S_SINF) begin
      div_hi    = DEN_W'(prod[60:40]);
      div_lo    = {prod[39:30], 10'd0};
      div_den   = DEN_W'(norm);
      div_start = (prod[60:30] < {norm, 10'd0});
    end
  end

  always_comb begin
    mul_a = 32'(q);
    mul_b = 32'(cfg.saturation_amount);
    case (state)
      S_PHASE:  begin mul_a = 32'(pf); mul_b = PI_Q30; end
      S_T:      begin mul_a = 32'(prod[50:20]); mul_b = 32'(prod[50:20]); end
      S_RMUL:   begin mul_a = t2; mul_b = 32'(r); end
      S_RDIV:   begin mul_a = prod[61:30]; mul_b = kd[31:0]; end
      S_SIN:    begin mul_a = 32'(t); mul_b = 32'(r); end
      S_CEIL_M: begin mul_a = 32'(y); mul_b = 32'(cfg.ceiling_amp); end
      default:  ;
    endcase
  end

  assign pop       = (state == S_IDLE) && !qstat.empty;
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            ent   <= head;
            ch    <= 1'b0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (div_start) begin
            state <= S_DIV1;
          end else begin
            q     <= ONE_Q20;
            state <= S_PHASE_M;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            q     <= {1'b0, div_q};
            state <= S_PHASE_M;
          end
        end
        S_PHASE_M: begin
          if (cfg.saturation_amount == '0) begin
            y     <= q;
            state <= S_CEIL_M;
          end else begin
            state <= S_PHASE;
          end
        end
        S_PHASE: state <= S_T;
        S_T: begin
          t     <= prod[50:20];
          state <= S_T2;
        end
        S_T2: begin
          t2    <= prod[61:30];
          r     <= ONE_Q30;
          kidx  <= '0;
          state <= S_RMUL;
        end
        S_RMUL: state <= S_RDIV;
        S_RDIV: begin
          x     <= prod[61:30];
          state <= S_RCOR;
        end
        S_RCOR: begin
          r <= ONE_Q30 - 31'(qq);
          if (kidx == 3'(SINE_TERMS - 1)) begin
            state <= S_SIN;
          end else begin
            kidx  <= kidx + 1'b1;
            state <= S_RMUL;
          end
        end
        S_SIN: state <= S_SINF;
        S_SINF: begin
          if (div_start) begin
            state <= S_DIV2;
          end else begin
            y     <= ONE_Q20;
            state <= S_CEIL_M;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            y     <= {1'b0, div_q};
            state <= S_CEIL_M;
          end
        end
        S_CEIL_M: state <= S_CEIL;
        S_CEIL: begin
          if (ch) begin
            right_out <= res;
            state     <= S_OUT;
          end else begin
            left_out <= res;
            ch       <= 1'b1;
            state    <= S_LOAD;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SPL_ASSERT_IMPLY(a_left_bound, clk, rst, out_valid, (left_out <= 22'sd1048576) && (left_out >= -22'sd1048576))
  `SPL_ASSERT_IMPLY(a_right_bound, clk, rst, out_valid, (right_out <= 22'sd1048576) && (right_out >= -22'sd1048576))

endmodule
